// ----- rtl/sixcut_pkg.sv -----
package sixcut_pkg;

    // Datapath sizes
    localparam int CHANNELS  = 6;
    localparam int TIME_BITS = 32;
    localparam int CUR_W     = 16;
    localparam int FUNC_W    = 3;
    localparam int CFG_DW    = 32;
    localparam int ADDR_W    = 3;

    // Command codes carried by each input transaction
    typedef enum logic [FUNC_W-1:0] {
        FUNC_UPDATE   = 3'd0,
        FUNC_START    = 3'd1,
        FUNC_PAUSE    = 3'd2,
        FUNC_CONTINUE = 3'd3,
        FUNC_STOP     = 3'd4
    } t_func;

    // Register indexes (word address bit 2)
    localparam logic REG_MIN_CURRENT = 1'b0;
    localparam logic REG_MIN_TIME    = 1'b1;

    // Per-channel control from the command decode
    typedef struct packed {
        logic upd;   // accumulate while running
        logic clr;   // start or stop: clear uptime, set pass
    } t_chan_ctl;

endpackage

// ----- rtl/sixcut_regs.sv -----
module sixcut_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sixcut_pkg::ADDR_W-1:0] paddr,
    input  logic [sixcut_pkg::CFG_DW-1:0] pwdata,
    output logic [sixcut_pkg::CFG_DW-1:0] prdata,
    output logic                          pready,
    output logic [sixcut_pkg::CUR_W-1:0]  o_min_current,
    output logic [sixcut_pkg::TIME_BITS-1:0] o_min_time
);
    import sixcut_pkg::*;

    logic [CUR_W-1:0]     r_min_current;
    logic [TIME_BITS-1:0] r_min_time;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_current <= '0;
            r_min_time    <= '0;
        end else if (w_wr) begin
            if (paddr[2] == REG_MIN_CURRENT) begin
                r_min_current <= pwdata[CUR_W-1:0];
            end else begin
                r_min_time <= pwdata[TIME_BITS-1:0];
            end
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MIN_TIME) begin
            prdata = r_min_time;
        end else begin
            prdata = {{(CFG_DW-CUR_W){1'b0}}, r_min_current};
        end
    end

    assign o_min_current = r_min_current;
    assign o_min_time    = r_min_time;

endmodule

// ----- rtl/sixcut_chan.sv -----
module sixcut_chan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sixcut_pkg::t_chan_ctl            i_ctl,
    input  logic [sixcut_pkg::CUR_W-1:0]     i_sample,
    input  logic [sixcut_pkg::CUR_W-1:0]     i_min_current,
    input  logic [sixcut_pkg::TIME_BITS-1:0] i_min_time,
    input  logic [sixcut_pkg::TIME_BITS-1:0] i_delta,
    input  logic [sixcut_pkg::TIME_BITS-1:0] i_elapsed,
    output logic [sixcut_pkg::TIME_BITS-1:0] o_uptime,
    output logic                             o_pass
);
    import sixcut_pkg::*;

    logic [TIME_BITS-1:0] r_uptime, n_uptime;
    logic                 r_pass, n_pass;
    logic [TIME_BITS:0]   w_sum;
    logic [TIME_BITS-1:0] w_acc;
    logic [TIME_BITS-1:0] w_short;

    // Saturating accumulate when the sample meets the threshold
    assign w_sum   = {1'b0, r_uptime} + {1'b0, i_delta};
    assign w_acc   = (i_sample >= i_min_current)
                   ? (w_sum[TIME_BITS] ? '1 : w_sum[TIME_BITS-1:0])
                   : r_uptime;
    assign w_short = i_elapsed - w_acc;

    always_comb begin
        n_uptime = r_uptime;
        n_pass   = r_pass;
        if (i_ctl.clr) begin
            n_uptime = '0;
            n_pass   = 1'b1;
        end else if (i_ctl.upd) begin
            n_uptime = w_acc;
            n_pass   = (w_acc >= i_elapsed) || (w_short <= i_min_time);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uptime <= '0;
            r_pass   <= 1'b1;
        end else begin
            r_uptime <= n_uptime;
            r_pass   <= n_pass;
        end
    end

    assign o_uptime = r_uptime;
    assign o_pass   = r_pass;

endmodule

// ----- rtl/six_channel_current_uptime_tracker.sv -----
// Path: an accepted input transaction is held in the input register, then computed
// into the state/result registers, which then hold the result valid.
// Throughput: one transaction per cycle; a stalled result holds the state, the
// input register keeps the next transaction and input ready drops until it moves.
// Reset (synchronous, active low): not running, times zero, all channels pass.
module six_channel_current_uptime_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [sixcut_pkg::FUNC_W-1:0]    i_func,
    input  logic [sixcut_pkg::TIME_BITS-1:0] i_timestamp_ms,
    input  logic [sixcut_pkg::CUR_W-1:0]     i_current_1,
    input  logic [sixcut_pkg::CUR_W-1:0]     i_current_2,
    input  logic [sixcut_pkg::CUR_W-1:0]     i_current_3,
    input  logic [sixcut_pkg::CUR_W-1:0]     i_current_4,
    input  logic [sixcut_pkg::CUR_W-1:0]     i_current_5,
    input  logic [sixcut_pkg::CUR_W-1:0]     i_current_6,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sixcut_pkg::CHANNELS-1:0]  o_pass_mask,
    output logic [sixcut_pkg::TIME_BITS-1:0] o_elapsed_ms,
    output logic [sixcut_pkg::TIME_BITS-1:0] o_uptime_1,
    output logic [sixcut_pkg::TIME_BITS-1:0] o_uptime_2,
    output logic [sixcut_pkg::TIME_BITS-1:0] o_uptime_3,
    output logic [sixcut_pkg::TIME_BITS-1:0] o_uptime_4,
    output logic [sixcut_pkg::TIME_BITS-1:0] o_uptime_5,
    output logic [sixcut_pkg::TIME_BITS-1:0] o_uptime_6,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sixcut_pkg::ADDR_W-1:0]    paddr,
    input  logic [sixcut_pkg::CFG_DW-1:0]    pwdata,
    output logic [sixcut_pkg::CFG_DW-1:0]    prdata,
    output logic                             pready
);
    import sixcut_pkg::*;

    logic [CUR_W-1:0]     w_min_current;
    logic [TIME_BITS-1:0] w_min_time;

    // Input register
    logic                 r_in_valid;
    logic [FUNC_W-1:0]    r_func;
    logic [TIME_BITS-1:0] r_ts;
    logic [CUR_W-1:0]     r_cur [CHANNELS];
    logic [CUR_W-1:0]     w_cur [CHANNELS];

    // Tracker state (doubles as result register)
    logic                 r_out_valid;
    logic                 r_running, n_running;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;

    logic                 w_adv;
    logic [TIME_BITS-1:0] w_delta;
    logic [TIME_BITS-1:0] w_elapsed_upd;
    t_chan_ctl            w_ctl;
    logic [TIME_BITS-1:0] w_uptime [CHANNELS];
    logic [CHANNELS-1:0]  w_pass;

    sixcut_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_min_current (w_min_current),
        .o_min_time    (w_min_time)
    );

    // Handshake: compute when an item waits and the result slot is free
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    assign w_cur[0] = i_current_1;
    assign w_cur[1] = i_current_2;
    assign w_cur[2] = i_current_3;
    assign w_cur[3] = i_current_4;
    assign w_cur[4] = i_current_5;
    assign w_cur[5] = i_current_6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func <= i_func;
            r_ts   <= i_timestamp_ms;
            r_cur  <= w_cur;
        end
    end

    // Time differences, modulo 2^TIME_BITS
    assign w_delta       = r_ts - r_last;
    assign w_elapsed_upd = r_ts - r_start;

    // Command decode
    always_comb begin
        n_running = r_running;
        n_start   = r_start;
        n_last    = r_last;
        n_elapsed = r_elapsed;
        w_ctl     = '0;
        if (w_adv) begin
            case (t_func'(r_func))
                FUNC_UPDATE: begin
                    if (r_running) begin
                        w_ctl.upd = 1'b1;
                        n_elapsed = w_elapsed_upd;
                        n_last    = r_ts;
                    end
                end
                FUNC_START: begin
                    w_ctl.clr = 1'b1;
                    n_start   = r_ts;
                    n_last    = r_ts;
                    n_running = 1'b1;
                end
                FUNC_PAUSE: begin
                    n_running = 1'b0;
                end
                FUNC_CONTINUE: begin
                    n_running = 1'b1;
                    n_last    = r_ts;
                end
                FUNC_STOP: begin
                    w_ctl.clr = 1'b1;
                    n_running = 1'b0;
                    n_elapsed = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_running   <= 1'b0;
            r_start     <= '0;
            r_last      <= '0;
            r_elapsed   <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_running <= n_running;
            r_start   <= n_start;
            r_last    <= n_last;
            r_elapsed <= n_elapsed;
        end
    end

    // One datapath slice per probe
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        sixcut_chan u_chan (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_sample      (r_cur[g]),
            .i_min_current (w_min_current),
            .i_min_time    (w_min_time),
            .i_delta       (w_delta),
            .i_elapsed     (w_elapsed_upd),
            .o_uptime      (w_uptime[g]),
            .o_pass        (w_pass[g])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_pass_mask  = w_pass;
    assign o_elapsed_ms = r_elapsed;
    assign o_uptime_1   = w_uptime[0];
    assign o_uptime_2   = w_uptime[1];
    assign o_uptime_3   = w_uptime[2];
    assign o_uptime_4   = w_uptime[3];
    assign o_uptime_5   = w_uptime[4];
    assign o_uptime_6   = w_uptime[5];

endmodule

// ----- rtl/sixcut_chk.sv -----
module sixcut_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [sixcut_pkg::CHANNELS-1:0]  o_pass_mask,
    input logic [sixcut_pkg::TIME_BITS-1:0] o_elapsed_ms,
    input logic [sixcut_pkg::TIME_BITS-1:0] o_uptime_1,
    input logic [sixcut_pkg::TIME_BITS-1:0] o_uptime_6
);
    import sixcut_pkg::*;

    // No result comes out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_elapsed_ms)
            && $stable(o_pass_mask) && $stable(o_uptime_1))
        else $error("stalled result changed");

    // The first or last probe with uptime covering elapsed time cannot fail
    a_pass_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_uptime_1 >= o_elapsed_ms) |-> o_pass_mask[0])
        else $error("probe 1 failing with full uptime");

    a_pass_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_uptime_6 >= o_elapsed_ms) |-> o_pass_mask[CHANNELS-1])
        else $error("probe 6 failing with full uptime");

    // Zero elapsed time means every probe passes
    a_zero_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_elapsed_ms == '0) |-> (&o_pass_mask))
        else $error("failing probe with zero elapsed time");

endmodule

bind six_channel_current_uptime_tracker sixcut_chk u_chk (.*);
